/* sv/rhrb_pkg.sv */
`timescale 1ns / 1ps
package rhrb_pkg;

    // Ring geometry.
    localparam int CAPACITY  = 16;
    localparam int ROW_WORDS = 4;
    localparam int WORD_W    = 64;

    // Field widths of the stream items.
    localparam int IO_WORDS = 4;
    localparam int REQ_W    = 8;
    localparam int AGE_W    = 4;
    localparam int FILL_W   = 5;

    localparam int ROW_BITS = ROW_WORDS * WORD_W;
    localparam int IO_BITS  = IO_WORDS * WORD_W;

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int S_TDATA_W = ((REQ_W + IO_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((IO_BITS + AGE_W + FILL_W + 7) / 8) * 8;

    // Command queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Command codes carried in s_tuser.
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One classified command as it waits in the queue.
    typedef struct packed {
        logic                is_query;
        logic [CNT_W-1:0]    count;   // clamped row count of a query
        logic [CNT_W-1:0]    fill;    // rows held when the request was taken
        logic [PTR_W-1:0]    slot;    // push: target slot, query: newest slot
        logic [ROW_BITS-1:0] row;
    } cmd_t;

endpackage

/* sv/rhrb_ram.sv */
`timescale 1ns / 1ps
module rhrb_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/rhrb_front.sv */
`timescale 1ns / 1ps
module rhrb_front import rhrb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 q_full,
    output logic                 q_wr_en,
    output cmd_t                 q_wr_data
);

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [REQ_W-1:0] req;
    logic [IO_BITS-1:0] in_words;
    logic             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_wr_en  = accept;
    assign req      = s_tdata[REQ_W-1:0];
    assign in_words = s_tdata[REQ_W +: IO_BITS];

    // The front keeps its own pointer and fill count, so each command is
    // fully resolved before it enters the queue.
    always_comb begin
        wp_next   = wp_reg;
        held_next = held_reg;
        q_wr_data.is_query = (s_tuser == CMD_QUERY);
        q_wr_data.fill     = held_reg;
        q_wr_data.row      = ROW_BITS'(in_words);
        if (s_tuser == CMD_QUERY) begin
            q_wr_data.count = (REQ_W'(held_reg) < req) ? held_reg : CNT_W'(req);
            q_wr_data.slot  = (wp_reg == '0) ? PTR_W'(CAPACITY - 1) : wp_reg - 1'b1;
        end else begin
            q_wr_data.count = '0;
            q_wr_data.slot  = wp_reg;
            if (accept) begin
                wp_next = (wp_reg == PTR_W'(CAPACITY - 1)) ? '0 : wp_reg + 1'b1;
                if (held_reg != CNT_W'(CAPACITY)) begin
                    held_next = held_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            held_reg <= '0;
        end else begin
            wp_reg   <= wp_next;
            held_reg <= held_next;
        end
    end

endmodule

/* sv/rhrb_queue.sv */
`timescale 1ns / 1ps
module rhrb_queue import rhrb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_data
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

/* sv/rhrb_back.sv */
`timescale 1ns / 1ps
module rhrb_back import rhrb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  cmd_t                 q_head,
    output logic                 q_rd_en,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    logic                d_valid_reg;
    logic [PTR_W-1:0]    age_reg;
    logic                rvalid_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic                advance, do_write, issue, is_last, rd_en;
    logic [PTR_W:0]      addr_wide;
    logic [PTR_W-1:0]    rd_addr;
    logic [ROW_BITS-1:0] rd_data;
    logic [IO_BITS-1:0]  out_words;

    assign advance  = !d_valid_reg || m_tready;
    assign do_write = q_valid && !q_head.is_query;
    assign issue    = q_valid && q_head.is_query && advance;
    assign is_last  = (q_head.count == '0) || ((CNT_W'(idx_reg) + 1'b1) == q_head.count);
    assign rd_en    = issue && (q_head.count != '0);
    assign q_rd_en  = do_write || (issue && is_last);
    assign idx_next = (issue && is_last) ? '0 : (issue ? idx_reg + 1'b1 : idx_reg);

    // Slot of the row idx_reg steps back from the newest, wrapping the ring.
    always_comb begin
        if (idx_reg > q_head.slot) begin
            addr_wide = {1'b0, q_head.slot} + (PTR_W + 1)'(CAPACITY) - {1'b0, idx_reg};
        end else begin
            addr_wide = {1'b0, q_head.slot} - {1'b0, idx_reg};
        end
    end
    assign rd_addr = addr_wide[PTR_W-1:0];

    rhrb_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (do_write),
        .wr_addr (q_head.slot),
        .wr_data (q_head.row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (advance && issue) begin
            age_reg    <= idx_reg;
            rvalid_reg <= (q_head.count != '0);
            last_reg   <= is_last;
            fill_reg   <= q_head.fill;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            idx_reg <= idx_next;
            if (advance) begin
                d_valid_reg <= issue;
            end
        end
    end

    assign out_words = rvalid_reg ? IO_BITS'(rd_data) : '0;
    assign m_tvalid  = d_valid_reg;
    assign m_tuser   = rvalid_reg;
    assign m_tlast   = last_reg;
    assign m_tdata   = M_TDATA_W'({FILL_W'(fill_reg), AGE_W'(age_reg), out_words});

endmodule

/* sv/row_history_ring_buffer.sv */
`timescale 1ns / 1ps
// Ring buffer of the most recent rows, each row four 64-bit words.
// Requests enter on the s_ channel; s_tuser selects a push (0) or a query (1).
// A push stores its row over the oldest one once the ring is full and gives
// no result. A query returns the latest requested_rows rows (clamped to the
// rows held) on the m_ channel, newest first, one per cycle while the receiver
// takes them, with m_tlast on the final row. A query that finds nothing to
// return gives a single result with m_tuser (row_valid) low and m_tlast high.
// Every result carries the fill count at the time the query was accepted.
// With the back idle, a query passes through the command queue and then the
// row memory and output registers before its first result appears on m_.
// The back works one command at a time from the queue head: a push writes
// its row, and a query reads its rows one at a time through the single read
// port of the row memory. A two-entry command queue sits between the front,
// which classifies requests, and the back, which works them.
// Reset clears the write pointer and the fill count; the ring is empty at once
// and needs no clearing pass. When the receiver stalls, the held result stays
// on m_ and the back holds queries but still writes pushed rows, while the
// front keeps taking requests until the queue is full.
module row_history_ring_buffer import rhrb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: requested_rows, in_word0, in_word1, in_word2, in_word3
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: out_word0, out_word1, out_word2, out_word3, age_index,
    // fill_count, zero padding
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: row_valid
    output logic                 m_tuser,
    output logic                 m_tlast
);

    // Command path from the front into the queue.
    logic q_wr_en, q_full;
    cmd_t q_wr_data;

    // Command path from the queue into the back.
    logic q_rd_en, q_valid;
    cmd_t q_head;

    rhrb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    rhrb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_en    (q_rd_en),
        .rd_valid (q_valid),
        .rd_data  (q_head)
    );

    // The back writes pushed rows and walks queried rows out of the memory.
    rhrb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_rd_en  (q_rd_en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
